### hw/rtl/bounded_double_ended_queue_macros.svh
// Assertion macros used by the checker file of the double-ended queue.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BDEQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/bdeq_pkg.sv
// Package of the double-ended queue: word type, operation and status codes,
// cell control codes and the control struct sent down the cell chain.
// No dependencies.
package bdeq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int MODE_W    = 3;
    localparam int STATUS_W  = 2;

    typedef logic signed [31:0] t_word;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LIST       = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // The operation that every cell carries out.
    localparam logic [2:0] CELL_HOLD        = 3'd0;
    localparam logic [2:0] CELL_SHIFT_REAR  = 3'd1;
    localparam logic [2:0] CELL_SHIFT_FRONT = 3'd2;
    localparam logic [2:0] CELL_LOAD_NEXT   = 3'd3;
    localparam logic [2:0] CELL_ROTATE      = 3'd4;

    typedef struct packed {
        logic [2:0] op;
        t_word      word;   // word entering at the front or at the first free cell
        t_word      head;   // front word, wrapped to the tail when rotating
    } t_cell_ctl;

endpackage

### hw/rtl/bdeq_in_if.sv
// Valid/ready channel interfaces of the double-ended queue: operation words in,
// result words out. Depends on bdeq_pkg.
interface bdeq_in_if
    import bdeq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    t_word             value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface bdeq_out_if
    import bdeq_pkg::*;
();
    logic                valid;
    logic                ready;
    t_word               value_res;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, output value_res, output status, output last,
                    input ready);
    modport sink   (input valid, input value_res, input status, input last,
                    output ready);
endinterface

### hw/rtl/bdeq_cell.sv
// One storage cell of the queue chain: holds a word and takes it from a
// neighbor, the incoming word or the front word. Depends on bdeq_pkg.
module bdeq_cell
    import bdeq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_word     i_left,
    input  t_word     i_right,
    input  logic      i_at_tail,
    input  logic      i_at_next,
    output t_word     o_word
);

    t_word r_word;
    t_word n_word;

    always_comb begin
        n_word = r_word;
        unique case (i_ctl.op)
            CELL_HOLD:        n_word = r_word;
            CELL_SHIFT_REAR:  n_word = i_left;
            CELL_SHIFT_FRONT: n_word = i_right;
            CELL_LOAD_NEXT:   n_word = i_at_next ? i_ctl.word : r_word;
            // the front word wraps into the tail cell
            CELL_ROTATE:      n_word = i_at_tail ? i_ctl.head : i_right;
            default:          n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

### hw/rtl/bounded_double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit words, built as a chain of cells
// with the front word always in cell 0.
// Channels: i_in carries one operation word (mode, value); o_out carries
// result words (value_res, status, last). Both are valid/ready.
// Push front, push rear, pop front and pop rear each give one result word,
// registered, the cycle after acceptance. Listing gives one result per stored
// word: the chain rotates by one cell per result, so a listing holds the input
// until its last result and leaves the order intact.
// An empty listing gives one result. Unused mode codes are taken and dropped.
// Throughput: one operation per cycle while the receiver keeps up and no listing
// is in progress; the single output register is the only buffer.
// When the receiver stalls, the result holds and no new word is taken, and a
// listing pauses without rotating.
// Reset (synchronous, active low) empties the queue and drops any pending
// result; cell contents are not cleared.
// Depends on bdeq_pkg, bdeq_in_if, bdeq_out_if and bdeq_cell.
module bounded_double_ended_queue
    import bdeq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bdeq_in_if.sink     i_in,
    bdeq_out_if.source  o_out
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LIST = 1'b1;

    logic                r_state, n_state;
    logic [OCC_W-1:0]    r_occ, n_occ;
    logic [OCC_W-1:0]    r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    t_word               r_out_value, n_out_value;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic                r_out_last, n_out_last;

    t_cell_ctl           w_ctl;
    t_word               w_words [DEPTH];
    logic                w_in_fire;
    logic                w_out_free;
    logic                w_full;
    logic                w_empty;
    logic [OCC_W-1:0]    w_occ_m1;
    logic [IDX_W-1:0]    w_tail_idx;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_full     = (r_occ == OCC_W'(DEPTH));
    assign w_empty    = (r_occ == '0);
    assign w_occ_m1   = r_occ - OCC_W'(1);
    assign w_tail_idx = w_occ_m1[IDX_W-1:0];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            t_word w_left;
            t_word w_right;
            if (gi == 0) begin : g_first
                assign w_left = w_ctl.word;
            end else begin : g_mid
                assign w_left = w_words[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_end
                assign w_right = w_words[0];
            end else begin : g_inner
                assign w_right = w_words[gi+1];
            end
            bdeq_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (w_ctl),
                .i_left    (w_left),
                .i_right   (w_right),
                .i_at_tail (r_occ == OCC_W'(gi + 1)),
                .i_at_next (r_occ == OCC_W'(gi)),
                .o_word    (w_words[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        w_ctl.op     = CELL_HOLD;
        w_ctl.word   = i_in.value;
        w_ctl.head   = w_words[0];

        if (w_in_fire) begin
            n_out_value  = '0;
            n_out_status = ST_OK;
            n_out_last   = 1'b1;
            unique case (i_in.mode)
                MODE_PUSH_FRONT: begin
                    n_out_valid = 1'b1;
                    if (w_full) begin
                        n_out_status = ST_FULL;
                    end else begin
                        w_ctl.op = CELL_SHIFT_REAR;
                        n_occ    = r_occ + OCC_W'(1);
                    end
                end
                MODE_PUSH_REAR: begin
                    n_out_valid = 1'b1;
                    if (w_full) begin
                        n_out_status = ST_FULL;
                    end else begin
                        w_ctl.op = CELL_LOAD_NEXT;
                        n_occ    = r_occ + OCC_W'(1);
                    end
                end
                MODE_POP_FRONT: begin
                    n_out_valid = 1'b1;
                    if (w_empty) begin
                        n_out_status = ST_EMPTY;
                    end else begin
                        n_out_value = w_words[0];
                        w_ctl.op    = CELL_SHIFT_FRONT;
                        n_occ       = w_occ_m1;
                    end
                end
                MODE_POP_REAR: begin
                    n_out_valid = 1'b1;
                    if (w_empty) begin
                        n_out_status = ST_EMPTY;
                    end else begin
                        n_out_value = w_words[w_tail_idx];
                        n_occ       = w_occ_m1;
                    end
                end
                MODE_LIST: begin
                    if (w_empty) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_EMPTY;
                    end else begin
                        n_state = S_LIST;
                        n_cnt   = '0;
                    end
                end
                default: begin
                    // unused codes: drop the word
                end
            endcase
        end else if (r_state == S_LIST && w_out_free) begin
            // emit the front word and rotate it to the tail
            n_out_valid  = 1'b1;
            n_out_value  = w_words[0];
            n_out_status = ST_OK;
            n_out_last   = (r_cnt == w_occ_m1);
            w_ctl.op     = CELL_ROTATE;
            n_cnt        = r_cnt + OCC_W'(1);
            if (r_cnt == w_occ_m1) begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.value_res = r_out_value;
    assign o_out.status    = r_out_status;
    assign o_out.last      = r_out_last;

endmodule

### hw/rtl/bdeq_checker.sv
// Port-level checks of the double-ended queue, bound to the top level.
// Depends on bdeq_pkg and bounded_double_ended_queue_macros.svh.
`include "bounded_double_ended_queue_macros.svh"

module bdeq_checker
    import bdeq_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic [MODE_W-1:0]   i_in_mode,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input t_word               i_out_value,
    input logic [STATUS_W-1:0] i_out_status,
    input logic                i_out_last
);

    `BDEQ_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_value) && $stable(i_out_status) && $stable(i_out_last), "result word changed while stalled")
    `BDEQ_ASSERT_NOW(a_empty_form, i_out_valid && i_out_status == ST_EMPTY, i_out_value == '0 && i_out_last, "empty report must be zero and last")
    `BDEQ_ASSERT_NOW(a_full_form, i_out_valid && i_out_status == ST_FULL, i_out_value == '0 && i_out_last, "full report must be zero and last")
    `BDEQ_ASSERT_NEXT(a_push_result, i_in_valid && i_in_ready && (i_in_mode == MODE_PUSH_FRONT || i_in_mode == MODE_PUSH_REAR), i_out_valid && i_out_last && i_out_value == '0 && i_out_status != ST_EMPTY, "push must report at once")

endmodule

bind bounded_double_ended_queue bdeq_checker u_bdeq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_mode    (i_in.mode),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_value  (o_out.value_res),
    .i_out_status (o_out.status),
    .i_out_last   (o_out.last)
);
